### hw/rtl/utlc_pkg.sv
package utlc_pkg;

    // Hard cap on letters per text; the register value is clipped to it.
    localparam int MAX_TEXT_LETTERS = 256;

    localparam int COUNT_W  = 9;
    localparam int LETTER_W = 7;
    localparam int LEAD_W   = 5;
    localparam int CP_W     = 11;

    localparam logic [COUNT_W-1:0] LIMIT_CAP =
        COUNT_W'((MAX_TEXT_LETTERS > (2 ** COUNT_W) - 1) ? (2 ** COUNT_W) - 1
                                                          : MAX_TEXT_LETTERS);
    localparam logic [COUNT_W-1:0] MAX_LETTERS_RESET = 9'd256;

    // Letter codes
    localparam logic [LETTER_W-1:0] CODE_NONE      = 7'd0;
    localparam logic [LETTER_W-1:0] CODE_SEP_SPACE = 7'd10;
    localparam logic [LETTER_W-1:0] CODE_SEP_JOIN  = 7'd11;
    localparam logic [LETTER_W-1:0] CODE_LATIN     = 7'd12;
    localparam logic [LETTER_W-1:0] CODE_CYRILLIC  = 7'd38;
    localparam logic [LETTER_W-1:0] CODE_YO        = 7'd43;
    localparam logic [LETTER_W-1:0] CODE_BAR       = 7'd70;

    // Code points of the Cyrillic block
    localparam logic [CP_W-1:0] CP_UPPER_A  = 11'd1040;
    localparam logic [CP_W-1:0] CP_UPPER_YA = 11'd1071;
    localparam logic [CP_W-1:0] CP_LOWER_A  = 11'd1072;
    localparam logic [CP_W-1:0] CP_LOWER_YA = 11'd1103;
    localparam logic [CP_W-1:0] CP_UPPER_YO = 11'd1025;
    localparam logic [CP_W-1:0] CP_LOWER_YO = 11'd1105;

    // Raw byte values
    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_BAR     = 8'h7C;
    localparam logic [7:0] BYTE_ZERO    = 8'h30;
    localparam logic [7:0] BYTE_NINE    = 8'h39;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;

    typedef struct packed {
        logic [LEAD_W-1:0]  lead_bits;
        logic               lead_pending;
        logic [COUNT_W-1:0] count;
        logic               prev_sep;
        logic               finished;
    } t_state;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                has_letter;
        logic                last;
        logic [COUNT_W-1:0]  letter_count;
        logic                unknown_sequence;
    } t_result;

endpackage

### hw/rtl/utlc_text_if.sv
interface utlc_text_if;
    import utlc_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       new_text;

    modport source (output valid, output text_byte, output new_text, input ready);
    modport sink   (input valid, input text_byte, input new_text, output ready);
endinterface

### hw/rtl/utlc_code_if.sv
interface utlc_code_if;
    import utlc_pkg::*;

    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                has_letter;
    logic                last;
    logic [COUNT_W-1:0]  letter_count;
    logic                unknown_sequence;

    modport source (output valid, output letter, output has_letter, output last,
                    output letter_count, output unknown_sequence, input ready);
    modport sink   (input valid, input letter, input has_letter, input last,
                    input letter_count, input unknown_sequence, output ready);
endinterface

### hw/rtl/utf8_text_to_letter_codes.sv
// Channel   Dir  Payload                                          Beat
// i_text    in   text_byte[7:0], new_text                         one raw text byte
// o_codes   out  letter[6:0], has_letter, last, letter_count[8:0],
//                unknown_sequence                                 one code or end marker
// i_cfg     in   i_cfg_we, i_cfg_wdata[8:0] (max_letters)         register write
//
// One byte per cycle while o_codes does not stall; an input beat passes the input
// register, then the per-byte decode into the result register.
// Bytes that produce no code leave no result beat.
// Reset is synchronous, active low: state clears, max_letters returns to 256.
// A stall on o_codes holds the result and the input register; i_text.ready
// drops only when both are full and the result is not being taken.
module utf8_text_to_letter_codes (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    utlc_text_if.sink                      i_text,
    utlc_code_if.source                    o_codes,
    input  logic                           i_cfg_we,
    input  logic [utlc_pkg::COUNT_W-1:0]   i_cfg_wdata
);
    import utlc_pkg::*;

    logic               r_s1_valid;
    logic [7:0]         r_s1_byte;
    logic               r_s1_new_text;
    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_limit;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    logic               step_valid;
    logic               out_free;
    logic               in_ready;

    // Result slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || o_codes.ready;
    assign in_ready = !r_s1_valid || out_free;
    assign i_text.ready = in_ready;

    utlc_step u_step (
        .i_byte     (r_s1_byte),
        .i_new_text (r_s1_new_text),
        .i_state    (r_state),
        .i_limit    (r_limit),
        .o_state    (n_state),
        .o_valid    (step_valid),
        .o_result   (n_out)
    );

    // Input register: take a beat whenever the held byte can move on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_text.valid;
        end
        if (in_ready && i_text.valid) begin
            r_s1_byte     <= i_text.text_byte;
            r_s1_new_text <= i_text.new_text;
        end
    end

    // Limit in use: the register value clipped to the hard cap, kept ready-made.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= (MAX_LETTERS_RESET > LIMIT_CAP) ? LIMIT_CAP : MAX_LETTERS_RESET;
        end else if (i_cfg_we) begin
            r_limit <= (i_cfg_wdata > LIMIT_CAP) ? LIMIT_CAP : i_cfg_wdata;
        end
    end

    // Advance the text state and load the result slot together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && step_valid;
            if (r_s1_valid) begin
                r_state <= n_state;
            end
        end
        if (out_free && r_s1_valid && step_valid) begin
            r_out <= n_out;
        end
    end

    assign o_codes.valid            = r_out_valid;
    assign o_codes.letter           = r_out.letter;
    assign o_codes.has_letter       = r_out.has_letter;
    assign o_codes.last             = r_out.last;
    assign o_codes.letter_count     = r_out.letter_count;
    assign o_codes.unknown_sequence = r_out.unknown_sequence;
endmodule

### hw/rtl/utlc_step.sv
module utlc_step (
    input  logic [7:0]                      i_byte,
    input  logic                            i_new_text,
    input  utlc_pkg::t_state                i_state,
    input  logic [utlc_pkg::COUNT_W-1:0]    i_limit,
    output utlc_pkg::t_state                o_state,
    output logic                            o_valid,
    output utlc_pkg::t_result               o_result
);
    import utlc_pkg::*;

    localparam logic [1:0] SEPK_NONE  = 2'd0;
    localparam logic [1:0] SEPK_SPACE = 2'd1;
    localparam logic [1:0] SEPK_JOIN  = 2'd2;

    function automatic logic [1:0] sep_kind(input logic [7:0] b);
        logic [1:0] k;
        unique case (b)
            8'h20, 8'h09, 8'h5F, 8'h40, 8'h2E, 8'h2F, 8'h2B, 8'h5C, 8'h22, 8'h27,
            8'h3D, 8'h25, 8'h24, 8'h23, 8'h21, 8'h3F, 8'h28, 8'h29, 8'h7B, 8'h7D,
            8'h5B, 8'h5D: k = SEPK_SPACE;
            8'h2D, 8'h5E, 8'h26, 8'h2A: k = SEPK_JOIN;
            default: k = SEPK_NONE;
        endcase
        return k;
    endfunction

    t_state              s;
    logic [CP_W-1:0]     cp;
    logic [CP_W-1:0]     cp_off;
    logic [7:0]          byte_off;
    logic [1:0]          sk;
    logic                do_emit;
    logic                do_end;
    logic [LETTER_W-1:0] code;
    logic                unknown;
    logic [COUNT_W-1:0]  count_inc;
    logic                reach;

    always_comb begin
        s = i_state;
        if (i_new_text) begin
            s = '0;
        end

        cp        = {s.lead_bits, i_byte[5:0]};
        sk        = sep_kind(i_byte);
        count_inc = s.count + COUNT_W'(1);
        reach     = count_inc >= i_limit;
        do_emit   = 1'b0;
        do_end    = 1'b0;
        code      = CODE_NONE;
        unknown   = 1'b0;
        cp_off    = '0;
        byte_off  = '0;
        o_state   = s;

        if (s.finished) begin
            // drop bytes until the next text starts
        end else if (s.count >= i_limit) begin
            do_end = 1'b1;
        end else if (s.lead_pending && i_byte[7:6] == 2'b10) begin
            o_state.lead_pending = 1'b0;
            do_emit = 1'b1;
            if (cp >= CP_UPPER_A && cp <= CP_UPPER_YA) begin
                cp_off = cp - CP_UPPER_A + CP_W'(CODE_CYRILLIC);
                code   = cp_off[LETTER_W-1:0];
            end else if (cp >= CP_LOWER_A && cp <= CP_LOWER_YA) begin
                cp_off = cp - CP_LOWER_A + CP_W'(CODE_CYRILLIC);
                code   = cp_off[LETTER_W-1:0];
            end else if (cp == CP_UPPER_YO || cp == CP_LOWER_YO) begin
                code = CODE_YO;
            end else begin
                unknown = 1'b1;
            end
        end else begin
            // a lone lead is dropped; this byte is handled on its own
            o_state.lead_pending = 1'b0;
            if (i_byte == BYTE_NUL || i_byte == BYTE_LF) begin
                do_end = 1'b1;
            end else if (i_byte >= BYTE_ZERO && i_byte <= BYTE_NINE) begin
                byte_off = i_byte - BYTE_ZERO;
                code     = byte_off[LETTER_W-1:0];
                do_emit  = 1'b1;
            end else if (sk != SEPK_NONE) begin
                if (s.count != '0 && !s.prev_sep) begin
                    code    = (sk == SEPK_JOIN) ? CODE_SEP_JOIN : CODE_SEP_SPACE;
                    do_emit = 1'b1;
                end
            end else if (i_byte >= BYTE_LOWER_A && i_byte <= BYTE_LOWER_Z) begin
                byte_off = i_byte - BYTE_LOWER_A + 8'(CODE_LATIN);
                code     = byte_off[LETTER_W-1:0];
                do_emit  = 1'b1;
            end else if (i_byte >= BYTE_UPPER_A && i_byte <= BYTE_UPPER_Z) begin
                byte_off = i_byte - BYTE_UPPER_A + 8'(CODE_LATIN);
                code     = byte_off[LETTER_W-1:0];
                do_emit  = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                o_state.lead_bits    = i_byte[LEAD_W-1:0];
                o_state.lead_pending = 1'b1;
            end else if (i_byte == BYTE_BAR) begin
                code    = CODE_BAR;
                do_emit = 1'b1;
            end
        end

        o_result.letter           = code;
        o_result.has_letter       = do_emit;
        o_result.last             = do_end;
        o_result.letter_count     = s.count;
        o_result.unknown_sequence = unknown;

        if (do_emit) begin
            o_state.count        = count_inc;
            o_state.prev_sep     = (code == CODE_SEP_SPACE || code == CODE_SEP_JOIN);
            o_result.letter_count = count_inc;
            o_result.last        = reach;
            if (reach) begin
                o_state.finished     = 1'b1;
                o_state.lead_pending = 1'b0;
            end
        end
        if (do_end) begin
            o_state.finished     = 1'b1;
            o_state.lead_pending = 1'b0;
        end

        o_valid = do_emit || do_end;
    end
endmodule

### hw/rtl/utlc_checker.sv
module utlc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [utlc_pkg::LETTER_W-1:0]  i_letter,
    input  logic                           i_has_letter,
    input  logic                           i_last,
    input  logic [utlc_pkg::COUNT_W-1:0]   i_letter_count,
    input  logic                           i_unknown_sequence
);
    import utlc_pkg::*;

    // An end marker carries no code and always closes the text.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_has_letter) |-> (i_last && i_letter == CODE_NONE
                                            && !i_unknown_sequence))
        else $error("end marker malformed");

    // Unknown two-byte sequences report the null code.
    a_unknown_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_unknown_sequence) |-> (i_has_letter && i_letter == CODE_NONE))
        else $error("unknown sequence with nonzero code");

    // A letter is counted and stays within the code range.
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_has_letter) |-> (i_letter_count != '0 && i_letter <= CODE_BAR))
        else $error("letter code or count out of range");

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_letter)
            && $stable(i_has_letter) && $stable(i_last) && $stable(i_letter_count)
            && $stable(i_unknown_sequence)))
        else $error("stalled result changed");
endmodule

bind utf8_text_to_letter_codes utlc_checker u_utlc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_codes.valid),
    .i_out_ready        (o_codes.ready),
    .i_letter           (o_codes.letter),
    .i_has_letter       (o_codes.has_letter),
    .i_last             (o_codes.last),
    .i_letter_count     (o_codes.letter_count),
    .i_unknown_sequence (o_codes.unknown_sequence)
);

### sim/tb_utf8_text_to_letter_codes.sv
`timescale 1ns / 100ps

module tb_utf8_text_to_letter_codes;
    import utlc_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    // Margin past the input and result registers; also covers a byte still in the
    // decoder that produces no code.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       new_text;
    } t_text_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;

    utlc_text_if text_ch ();
    utlc_code_if code_ch ();

    utf8_text_to_letter_codes dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (text_ch),
        .o_codes     (code_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Bytes waiting to go out, and codes the block owes us, oldest first.
    t_text_beat pending_bytes [$];
    t_result    expected_codes [$];

    // A byte is on the input channel (blocking flag, so the stimulus side sees
    // it in the same step the driver launches it).
    bit byte_on_wire = 1'b0;

    int unsigned sender_idle_pct   = 10;
    int unsigned receiver_idle_pct = 45;
    int unsigned queued_items      = 0;
    int unsigned mismatch_count    = 0;
    int unsigned cycle_count       = 0;

    // Converter state as the block should hold it; all of it clears on reset,
    // max_letters comes out of reset at 256.
    logic [COUNT_W-1:0] max_letters_reg = MAX_LETTERS_RESET;
    logic [LEAD_W-1:0]  lead_bits_held  = '0;
    logic               lead_held       = 1'b0;
    logic [COUNT_W-1:0] text_count      = '0;
    logic               text_prev_sep   = 1'b0;
    logic               text_done       = 1'b0;

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.new_text  = 1'b0;
        code_ch.ready     = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Bail out if the run hangs, e.g. a code that never comes back.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_utf8_text_to_letter_codes failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Expected-code computation
    // ------------------------------------------------------------------

    // Effective letter limit: the register, clipped to the hard cap.
    function automatic logic [COUNT_W-1:0] letter_limit();
        return (max_letters_reg < MAX_TEXT_LETTERS) ? max_letters_reg
                                                    : COUNT_W'(MAX_TEXT_LETTERS);
    endfunction

    // Classify a punctuation byte; code gets the separator it stands for.
    function automatic bit separator_code(input logic [7:0] b,
                                          output logic [LETTER_W-1:0] code);
        code = CODE_SEP_SPACE;
        case (b)
            " ", "\t", "_", "@", ".", "/", "+", "\\", "\"", "'", "=", "%", "$",
            "#", "!", "?", "(", ")", "{", "}", "[", "]":
                return 1'b1;
            "-", "^", "&", "*": begin
                code = CODE_SEP_JOIN;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Count one letter code; close the text when it reaches the limit.
    function automatic t_result emit_code(input logic [LETTER_W-1:0] code, input bit unknown);
        t_result r;
        text_count    = text_count + 1'b1;
        text_prev_sep = (code == CODE_SEP_SPACE) || (code == CODE_SEP_JOIN);
        r.letter           = code;
        r.has_letter       = 1'b1;
        r.last             = (text_count >= letter_limit());
        r.letter_count     = text_count;
        r.unknown_sequence = unknown;
        if (r.last) begin
            text_done = 1'b1;
            lead_held = 1'b0;
        end
        return r;
    endfunction

    // End marker: no letter, final count, text closed.
    function automatic t_result close_text();
        t_result r;
        text_done = 1'b1;
        lead_held = 1'b0;
        r = '0;
        r.last         = 1'b1;
        r.letter_count = text_count;
        return r;
    endfunction

    // Advance the converter by one accepted byte; returns 1 when a code comes out.
    function automatic bit convert_byte(input logic [7:0] b, input logic nt,
                                        output t_result r);
        logic [CP_W-1:0]     cp;
        logic [LETTER_W-1:0] sep;
        r = '0;
        if (nt) begin
            text_count     = '0;
            text_prev_sep  = 1'b0;
            lead_held      = 1'b0;
            lead_bits_held = '0;
            text_done      = 1'b0;
        end
        if (text_done)
            return 1'b0;
        // Limit already used up (zero limit or register lowered mid-text).
        if (text_count >= letter_limit()) begin
            r = close_text();
            return 1'b1;
        end
        if (lead_held) begin
            lead_held = 1'b0;
            if ((b & 8'hC0) == 8'h80) begin
                cp = {lead_bits_held, b[5:0]};
                if (cp >= CP_UPPER_A && cp <= CP_UPPER_YA)
                    r = emit_code(CODE_CYRILLIC + LETTER_W'(cp - CP_UPPER_A), 1'b0);
                else if (cp >= CP_LOWER_A && cp <= CP_LOWER_YA)
                    r = emit_code(CODE_CYRILLIC + LETTER_W'(cp - CP_LOWER_A), 1'b0);
                else if (cp == CP_UPPER_YO || cp == CP_LOWER_YO)
                    r = emit_code(CODE_YO, 1'b0);
                else
                    r = emit_code(CODE_NONE, 1'b1);
                return 1'b1;
            end
            // Not a continuation: drop the lead and take this byte by itself.
        end
        if (b == BYTE_NUL || b == BYTE_LF) begin
            r = close_text();
            return 1'b1;
        end
        if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
            r = emit_code(LETTER_W'(b - BYTE_ZERO), 1'b0);
            return 1'b1;
        end
        if (separator_code(b, sep)) begin
            if (text_count > 0 && !text_prev_sep) begin
                r = emit_code(sep, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (b >= BYTE_LOWER_A && b <= BYTE_LOWER_Z) begin
            r = emit_code(CODE_LATIN + LETTER_W'(b - BYTE_LOWER_A), 1'b0);
            return 1'b1;
        end
        if (b >= BYTE_UPPER_A && b <= BYTE_UPPER_Z) begin
            r = emit_code(CODE_LATIN + LETTER_W'(b - BYTE_UPPER_A), 1'b0);
            return 1'b1;
        end
        if ((b & 8'hE0) == 8'hC0) begin
            lead_bits_held = b[4:0];
            lead_held      = 1'b1;
            return 1'b0;
        end
        if (b == BYTE_BAR) begin
            r = emit_code(CODE_BAR, 1'b0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: hold each beat until taken, predict at acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_text
        t_text_beat next_beat;
        t_result    code;
        if (!i_rst_n) begin
            text_ch.valid <= 1'b0;
            byte_on_wire = 1'b0;
        end else begin
            if (text_ch.valid && text_ch.ready) begin
                if (convert_byte(text_ch.text_byte, text_ch.new_text, code))
                    expected_codes.push_back(code);
                byte_on_wire = 1'b0;
            end
            // Only a free channel may take a new beat or go idle; never drop
            // valid under a beat that has not been accepted.
            if (!byte_on_wire) begin
                if (pending_bytes.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_beat = pending_bytes.pop_front();
                    text_ch.valid     <= 1'b1;
                    text_ch.text_byte <= next_beat.text_byte;
                    text_ch.new_text  <= next_beat.new_text;
                    byte_on_wire = 1'b1;
                end else begin
                    text_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare each code beat with the oldest expectation
    // ------------------------------------------------------------------
    function automatic string show_code(input t_result r);
        return $sformatf("letter=%0d has_letter=%0b last=%0b count=%0d unknown=%0b",
                         r.letter, r.has_letter, r.last, r.letter_count,
                         r.unknown_sequence);
    endfunction

    always @(posedge i_clk) begin : check_codes
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            code_ch.ready <= 1'b0;
        end else begin
            if (code_ch.valid && code_ch.ready) begin
                got.letter           = code_ch.letter;
                got.has_letter       = code_ch.has_letter;
                got.last             = code_ch.last;
                got.letter_count     = code_ch.letter_count;
                got.unknown_sequence = code_ch.unknown_sequence;
                if (expected_codes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected code beat: %s", $realtime, show_code(got));
                end else begin
                    want = expected_codes.pop_front();
                    if (got.letter !== want.letter || got.has_letter !== want.has_letter ||
                        got.last !== want.last || got.letter_count !== want.letter_count ||
                        got.unknown_sequence !== want.unknown_sequence) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: code mismatch: expected %s, got %s",
                                     $realtime, show_code(want), show_code(got));
                    end
                end
            end
            code_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic nt);
        t_text_beat beat;
        beat.text_byte = b;
        beat.new_text  = nt;
        pending_bytes.push_back(beat);
        queued_items++;
    endtask

    // Wait for every byte to be taken and every code to come back, then let
    // the pipeline empty out (bytes that produce no code leave no trace).
    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || byte_on_wire || expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_letters(input logic [COUNT_W-1:0] value);
        wait_for_drain();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        max_letters_reg = value;
    endtask

    // One random text: mostly well-formed tokens (letters, digits, separators,
    // Cyrillic pairs), with some foreign pairs, lone leads, raw bytes,
    // stray new_text flags and missing terminators.
    task automatic queue_random_text(input int max_len);
        int                  len;
        int                  kind;
        int                  pick;
        logic                nt;
        logic [7:0]          b;
        logic [CP_W-1:0]     cp;
        logic [LETTER_W-1:0] sep;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            nt   = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                b = $urandom_range(0, 1) ? BYTE_LOWER_A : BYTE_UPPER_A;
                queue_byte(b + 8'($urandom_range(0, 25)), nt);
            end else if (kind < 35) begin
                queue_byte(BYTE_ZERO + 8'($urandom_range(0, 9)), nt);
            end else if (kind < 50) begin
                do b = 8'($urandom_range(0, 255)); while (!separator_code(b, sep));
                queue_byte(b, nt);
            end else if (kind < 65) begin
                pick = $urandom_range(0, 65);
                if (pick < 64)
                    cp = CP_UPPER_A + CP_W'(pick);
                else if (pick == 64)
                    cp = CP_UPPER_YO;
                else
                    cp = CP_LOWER_YO;
                queue_byte({3'b110, cp[10:6]}, nt);
                queue_byte({2'b10, cp[5:0]}, 1'b0);
            end else if (kind < 70) begin
                queue_byte(8'($urandom_range(8'hC0, 8'hDF)), nt);
                queue_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else if (kind < 75) begin
                queue_byte(8'($urandom_range(8'hC0, 8'hDF)), nt);
            end else if (kind < 80) begin
                queue_byte(BYTE_BAR, nt);
            end else begin
                queue_byte(8'($urandom()), nt);
            end
        end
        if ($urandom_range(0, 9) != 0)
            queue_byte($urandom_range(0, 1) ? BYTE_NUL : BYTE_LF, 1'b0);
    endtask

    task automatic run_random_phase(input int unsigned items, input int max_len);
        int unsigned start;
        start = queued_items;
        while (queued_items - start < items)
            queue_random_text(max_len);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text at the reset limit: every code class and edge byte.
        queue_byte("A", 1'b1);        // first Latin upper
        queue_byte("z", 1'b0);        // last Latin lower
        queue_byte("0", 1'b0);
        queue_byte("9", 1'b0);
        queue_byte(" ", 1'b0);        // separator after a letter
        queue_byte("-", 1'b0);        // back-to-back separator, dropped
        queue_byte(BYTE_BAR, 1'b0);
        queue_byte("*", 1'b0);        // joining separator
        queue_byte(8'hD0, 1'b0);      // first capital Cyrillic letter
        queue_byte(8'h90, 1'b0);
        queue_byte(8'hD1, 1'b0);      // last small Cyrillic letter
        queue_byte(8'h8F, 1'b0);
        queue_byte(8'hD0, 1'b0);      // capital Yo
        queue_byte(8'h81, 1'b0);
        queue_byte(8'hD1, 1'b0);      // small Yo
        queue_byte(8'h91, 1'b0);
        queue_byte(8'hC2, 1'b0);      // two-byte sequence outside Cyrillic
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hD0, 1'b0);      // lone lead, then a plain letter
        queue_byte("b", 1'b0);
        queue_byte(8'h80, 1'b0);      // stray continuation, skipped
        queue_byte(8'hFF, 1'b0);      // unused byte, skipped
        queue_byte(8'hDF, 1'b0);      // lead still pending at the terminator
        queue_byte(BYTE_LF, 1'b0);
        queue_byte("x", 1'b0);        // after the end, ignored
        queue_byte(".", 1'b1);        // separator at text start, dropped
        queue_byte(BYTE_NUL, 1'b0);   // empty text

        // Zero limit: the first byte closes the text, the next is ignored.
        set_max_letters('0);
        queue_byte("a", 1'b1);
        queue_byte("b", 1'b0);

        // Limit of one: the first letter is also the last.
        set_max_letters(COUNT_W'(1));
        queue_byte("a", 1'b1);
        queue_byte("b", 1'b0);
        queue_byte(" ", 1'b1);
        queue_byte("c", 1'b0);

        // Lower the limit in mid-text below what is already produced.
        set_max_letters(COUNT_W'(MAX_TEXT_LETTERS));
        queue_byte("a", 1'b1);
        repeat (4) queue_byte("q", 1'b0);
        set_max_letters(COUNT_W'(3));
        queue_byte("f", 1'b0);
        queue_byte("g", 1'b0);

        // Full-size text: run into the hard cap.
        set_max_letters(COUNT_W'(MAX_TEXT_LETTERS));
        queue_byte("k", 1'b1);
        repeat (259) queue_byte(BYTE_ZERO + 8'($urandom_range(0, 9)), 1'b0);

        run_random_phase(180, 30);

        // Swap the idle pattern and use a small limit so texts end on it.
        set_max_letters(COUNT_W'($urandom_range(2, 12)));
        sender_idle_pct   = 45;
        receiver_idle_pct = 10;
        run_random_phase(180, 14);

        // Full throughput, mid-range limit.
        set_max_letters(COUNT_W'($urandom_range(20, 200)));
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_phase(180, 40);

        wait_for_drain();
        if (mismatch_count == 0)
            $display("tb_utf8_text_to_letter_codes passed");
        else
            $display("tb_utf8_text_to_letter_codes failed");
        $finish;
    end

endmodule
